// ----- rtl/core/odo_pkg.sv -----
// odo_pkg: shared types, constants and helper functions for the odometry block
// no dependencies; used by every module and by the meas and pose interfaces of the block
`timescale 1ns / 1ps
package odo_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_CNT_W = 6;

	localparam logic [31:0]        GAIN_RESET      = 32'd1921311;
	localparam logic [31:0]        INV_TRACK_RESET = 32'd54120051;
	localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
	localparam logic [41:0]        RAD_US_TO_TURN  = 42'd2935890505101;
	localparam logic [48:0]        DIST_HALF       = 49'd1000000;
	// ceil(2^56 / 15625): divides by 2000000 after a shift by 7, exact below 2^42
	localparam logic [42:0]        DIST_RECIP      = 43'd4611686018428;

	localparam logic [7:0] REG_SPEED_GAIN     = 8'd0;
	localparam logic [7:0] REG_INV_HALF_TRACK = 8'd1;

	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_32 = 2'd1;
	localparam logic [1:0] SH_64 = 2'd2;

	typedef struct packed {
		logic signed [15:0] left_count;
		logic signed [15:0] right_count;
		logic [15:0]        step_us;
	} odo_in_t;

	typedef struct packed {
		logic signed [31:0] left_speed;
		logic signed [31:0] right_speed;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        heading;
	} odo_out_t;

	typedef struct packed {
		logic       en;
		logic       load;
		logic       bias_on;
		logic [6:0] bias_bit;
		logic [1:0] sh;
	} mac_ctl_t;

	function automatic logic [29:0] turn_atan(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd536870912;
			5'd1: v = 30'd316933406;
			5'd2: v = 30'd167458907;
			5'd3: v = 30'd85004756;
			5'd4: v = 30'd42667331;
			5'd5: v = 30'd21354465;
			5'd6: v = 30'd10679838;
			5'd7: v = 30'd5340245;
			5'd8: v = 30'd2670163;
			5'd9: v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			5'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	// signed 32-bit saturation of a sign and magnitude pair
	function automatic logic [31:0] sat_s32(input logic [63:0] q, input logic neg);
		logic [31:0] v;
		if (!neg) begin
			v = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		end else begin
			v = (q > 64'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
		end
		return v;
	endfunction

endpackage

// ----- rtl/core/odo_in_if.sv -----
// odo_in_if: measurement channel, valid/ready with the encoder payload
// depends on odo_pkg
`timescale 1ns / 1ps
interface odo_in_if;
	logic              valid;
	logic              ready;
	odo_pkg::odo_in_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/odo_out_if.sv -----
// odo_out_if: result channel, valid/ready with speeds and pose
// depends on odo_pkg
`timescale 1ns / 1ps
interface odo_out_if;
	logic              valid;
	logic              ready;
	odo_pkg::odo_out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/odo_cfg_if.sv -----
// odo_cfg_if: register write channel, valid/ready with index and write data
// no package dependency
`timescale 1ns / 1ps
interface odo_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] wdata;
	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/core/odo_mac.sv -----
// odo_mac: shared 33x32 multiplier with a 96-bit shifting accumulator
// depends on odo_pkg
`timescale 1ns / 1ps
module odo_mac (
	input  logic              clk,
	input  logic [32:0]       a,
	input  logic [31:0]       b,
	input  odo_pkg::mac_ctl_t ctl,
	output logic [95:0]       acc
);
	import odo_pkg::*;

	logic [64:0] prod;
	logic [95:0] prod_w;
	logic [95:0] prod_sh;
	logic [95:0] bias;
	logic [95:0] base;
	logic [95:0] acc_q;

	assign prod   = {32'd0, a} * {33'd0, b};
	assign prod_w = {31'd0, prod};

	always_comb begin
		case (ctl.sh)
			SH_0:    prod_sh = prod_w;
			SH_32:   prod_sh = prod_w << 32;
			SH_64:   prod_sh = prod_w << 64;
			default: prod_sh = '0;
		endcase
	end

	assign bias = ctl.bias_on ? (96'd1 << ctl.bias_bit) : '0;
	assign base = ctl.load ? bias : acc_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + prod_sh;
		end
	end

	assign acc = acc_q;
endmodule

// ----- rtl/core/odo_div.sv -----
// odo_div: distance division by the fixed divisor through a reciprocal product
// formed on the shared multiplier; depends on odo_pkg
`timescale 1ns / 1ps
module odo_div (
	input  logic        clk,
	input  logic        load,
	input  logic [48:0] num,
	input  logic        capture,
	input  logic [95:0] prod,
	output logic [31:0] nd_lo,
	output logic [9:0]  nd_hi,
	output logic [29:0] quo
);
	import odo_pkg::*;

	logic [48:0] num_r;
	logic [41:0] nd_q;
	logic [29:0] quo_q;

	// rounding bias, then the power-of-two part of the divisor
	assign num_r = num + DIST_HALF;

	always_ff @(posedge clk) begin
		if (load) begin
			nd_q <= num_r[48:7];
		end
		if (capture) begin
			quo_q <= prod[85:56];
		end
	end

	assign nd_lo = nd_q[31:0];
	assign nd_hi = nd_q[41:32];
	assign quo   = quo_q;
endmodule

// ----- rtl/core/odo_cordic.sv -----
// odo_cordic: rotation-mode cordic, one micro-rotation per cycle, gives cos and sin
// depends on odo_pkg
`timescale 1ns / 1ps
module odo_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        angle,
	output logic               done,
	output logic signed [33:0] cos_v,
	output logic signed [33:0] sin_v
);
	import odo_pkg::*;

	logic signed [33:0]      x_q, y_q, cos_q, sin_q;
	logic signed [32:0]      z_q;
	logic [1:0]              quad_q;
	logic [CORDIC_CNT_W-1:0] cnt_q;
	logic                    run_q, done_q;
	logic [31:0]             r;
	logic signed [33:0]      dx, dy;
	logic signed [32:0]      at;

	assign r  = angle + 32'h2000_0000;
	assign dx = y_q >>> cnt_q[4:0];
	assign dy = x_q >>> cnt_q[4:0];
	assign at = $signed({3'b000, turn_atan(cnt_q[4:0])});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			if (cnt_q == CORDIC_CNT_W'(CORDIC_STEPS)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= r[31:30];
			z_q    <= $signed({3'b000, r[29:0]}) - 33'sd536870912;
			x_q    <= CORDIC_INV_GAIN;
			y_q    <= '0;
		end else if (run_q) begin
			if (cnt_q == CORDIC_CNT_W'(CORDIC_STEPS)) begin
				// fold the quadrant back in
				case (quad_q)
					2'd0: begin
						cos_q <= x_q;
						sin_q <= y_q;
					end
					2'd1: begin
						cos_q <= -y_q;
						sin_q <= x_q;
					end
					2'd2: begin
						cos_q <= -x_q;
						sin_q <= -y_q;
					end
					default: begin
						cos_q <= y_q;
						sin_q <= -x_q;
					end
				endcase
			end else if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done  = done_q;
	assign cos_v = cos_q;
	assign sin_v = sin_q;
endmodule

// ----- rtl/core/diff_drive_odometry.sv -----
// diff_drive_odometry: top level, sequencer around the shared multiplier,
// cordic and reciprocal divider; depends on odo_pkg, the channel interfaces and submodules
//
//   channel | dir | payload
//   meas    | in  | left_count, right_count, step_us
//   pose    | out | left_speed, right_speed, pos_x, pos_y, heading
//   cfg     | in  | index, wdata (speed_gain, inv_half_track)
//
// a result is registered when the sequence ends; the next item is accepted after that
// the cordic started at acceptance holds the position steps until it is done; speed, distance and turn
// products run on the shared multiplier meanwhile
// meas is ready only while the sequencer is idle; a result waits in the output
// register and the next item stalls at its final step until that is taken
// arst_n clears pose and sequencer; registers return to their reset gains
`timescale 1ns / 1ps
module diff_drive_odometry (
	input  logic         clk,
	input  logic         arst_n,
	odo_in_if.sink       meas,
	odo_out_if.source    pose,
	odo_cfg_if.sink      cfg
);
	import odo_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SLM  = 5'd1;
	localparam logic [4:0] S_SLF  = 5'd2;
	localparam logic [4:0] S_SRM  = 5'd3;
	localparam logic [4:0] S_SRF  = 5'd4;
	localparam logic [4:0] S_RTM  = 5'd5;
	localparam logic [4:0] S_RTF  = 5'd6;
	localparam logic [4:0] S_DSM  = 5'd7;
	localparam logic [4:0] S_DSF  = 5'd8;
	localparam logic [4:0] S_RSM  = 5'd9;
	localparam logic [4:0] S_T0   = 5'd10;
	localparam logic [4:0] S_T1   = 5'd11;
	localparam logic [4:0] S_T2   = 5'd12;
	localparam logic [4:0] S_T3   = 5'd13;
	localparam logic [4:0] S_TF   = 5'd14;
	localparam logic [4:0] S_WAIT = 5'd15;
	localparam logic [4:0] S_DXM  = 5'd16;
	localparam logic [4:0] S_DXF  = 5'd17;
	localparam logic [4:0] S_DYM  = 5'd18;
	localparam logic [4:0] S_DYF  = 5'd19;
	localparam logic [4:0] S_OUT  = 5'd20;
	localparam logic [4:0] S_D0   = 5'd21;
	localparam logic [4:0] S_D1   = 5'd22;
	localparam logic [4:0] S_D2   = 5'd23;
	localparam logic [4:0] S_D3   = 5'd24;

	logic [4:0]         state_q;
	odo_in_t            in_q;
	logic [31:0]        gain_q, iht_q;
	logic signed [31:0] sl_q, sr_q, rate_q;
	logic [47:0]        m_q;
	logic               neg_q, dneg_q;
	logic [31:0]        turn_q, dx_q, dy_q;
	logic [31:0]        x_q, y_q, hd_q;
	odo_out_t           out_q;
	logic               ovalid_q;

	logic [32:0]        mac_a;
	logic [31:0]        mac_b;
	mac_ctl_t           mac_ctl;
	logic [95:0]        acc;

	logic               div_load, div_capture;
	logic [31:0]        nd_lo;
	logic [9:0]         nd_hi;
	logic [29:0]        quo;
	logic               cor_start, cor_done;
	logic signed [33:0] cor_cos, cor_sin;

	logic               take_in, out_load;
	logic [15:0]        lc_mag, rc_mag;
	logic signed [32:0] diff, sum;
	logic [32:0]        diff_mag, sum_mag;
	logic [31:0]        rate_mag;
	logic [33:0]        cos_neg, sin_neg;
	logic [31:0]        cos_mag, sin_mag;
	logic [31:0]        q_turn, q_dxy;

	odo_mac u_mac (
		.clk (clk),
		.a   (mac_a),
		.b   (mac_b),
		.ctl (mac_ctl),
		.acc (acc)
	);

	odo_div u_div (
		.clk     (clk),
		.load    (div_load),
		.num     (acc[48:0]),
		.capture (div_capture),
		.prod    (acc),
		.nd_lo   (nd_lo),
		.nd_hi   (nd_hi),
		.quo     (quo)
	);

	odo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (hd_q),
		.done   (cor_done),
		.cos_v  (cor_cos),
		.sin_v  (cor_sin)
	);

	assign meas.ready  = (state_q == S_IDLE);
	assign take_in     = meas.valid && meas.ready;
	assign cor_start   = take_in;
	assign div_load    = (state_q == S_DSF);
	assign div_capture = (state_q == S_RSM);
	assign out_load    = (state_q == S_OUT) && (!ovalid_q || pose.ready);
	assign cfg.ready   = 1'b1;

	assign lc_mag   = in_q.left_count[15] ? 16'(-in_q.left_count) : in_q.left_count;
	assign rc_mag   = in_q.right_count[15] ? 16'(-in_q.right_count) : in_q.right_count;
	assign diff     = {sr_q[31], sr_q} - {sl_q[31], sl_q};
	assign sum      = {sr_q[31], sr_q} + {sl_q[31], sl_q};
	assign diff_mag = diff[32] ? 33'(-diff) : diff;
	assign sum_mag  = sum[32] ? 33'(-sum) : sum;
	assign rate_mag = rate_q[31] ? 32'(-rate_q) : rate_q;
	assign cos_neg  = -cor_cos;
	assign sin_neg  = -cor_sin;
	assign cos_mag  = cor_cos[33] ? cos_neg[31:0] : cor_cos[31:0];
	assign sin_mag  = cor_sin[33] ? sin_neg[31:0] : cor_sin[31:0];
	assign q_turn   = neg_q ? (~acc[79:48] + 32'd1) : acc[79:48];
	assign q_dxy    = neg_q ? (~acc[61:30] + 32'd1) : acc[61:30];

	// operand selection for the shared multiplier
	always_comb begin
		mac_a   = '0;
		mac_b   = '0;
		mac_ctl = '0;
		case (state_q)
			S_SLM: begin
				mac_a   = {17'd0, lc_mag};
				mac_b   = gain_q;
				mac_ctl = '{en: 1'b1, load: 1'b1, bias_on: 1'b1, bias_bit: 7'd7, sh: SH_0};
			end
			S_SRM: begin
				mac_a   = {17'd0, rc_mag};
				mac_b   = gain_q;
				mac_ctl = '{en: 1'b1, load: 1'b1, bias_on: 1'b1, bias_bit: 7'd7, sh: SH_0};
			end
			S_RTM: begin
				mac_a   = diff_mag;
				mac_b   = iht_q;
				mac_ctl = '{en: 1'b1, load: 1'b1, bias_on: 1'b1, bias_bit: 7'd23, sh: SH_0};
			end
			S_DSM: begin
				mac_a   = sum_mag;
				mac_b   = {16'd0, in_q.step_us};
				mac_ctl = '{en: 1'b1, load: 1'b1, bias_on: 1'b0, bias_bit: 7'd0, sh: SH_0};
			end
			S_D0: begin
				mac_a   = {1'b0, nd_lo};
				mac_b   = DIST_RECIP[31:0];
				mac_ctl = '{en: 1'b1, load: 1'b1, bias_on: 1'b0, bias_bit: 7'd0, sh: SH_0};
			end
			S_D1: begin
				mac_a   = {1'b0, nd_lo};
				mac_b   = {21'd0, DIST_RECIP[42:32]};
				mac_ctl = '{en: 1'b1, load: 1'b0, bias_on: 1'b0, bias_bit: 7'd0, sh: SH_32};
			end
			S_D2: begin
				mac_a   = {23'd0, nd_hi};
				mac_b   = DIST_RECIP[31:0];
				mac_ctl = '{en: 1'b1, load: 1'b0, bias_on: 1'b0, bias_bit: 7'd0, sh: SH_32};
			end
			S_D3: begin
				mac_a   = {23'd0, nd_hi};
				mac_b   = {21'd0, DIST_RECIP[42:32]};
				mac_ctl = '{en: 1'b1, load: 1'b0, bias_on: 1'b0, bias_bit: 7'd0, sh: SH_64};
			end
			S_RSM: begin
				mac_a   = {1'b0, rate_mag};
				mac_b   = {16'd0, in_q.step_us};
				mac_ctl = '{en: 1'b1, load: 1'b1, bias_on: 1'b0, bias_bit: 7'd0, sh: SH_0};
			end
			S_T0: begin
				mac_a   = {1'b0, acc[31:0]};
				mac_b   = RAD_US_TO_TURN[31:0];
				mac_ctl = '{en: 1'b1, load: 1'b1, bias_on: 1'b1, bias_bit: 7'd47, sh: SH_0};
			end
			S_T1: begin
				mac_a   = {1'b0, m_q[31:0]};
				mac_b   = {22'd0, RAD_US_TO_TURN[41:32]};
				mac_ctl = '{en: 1'b1, load: 1'b0, bias_on: 1'b0, bias_bit: 7'd0, sh: SH_32};
			end
			S_T2: begin
				mac_a   = {17'd0, m_q[47:32]};
				mac_b   = RAD_US_TO_TURN[31:0];
				mac_ctl = '{en: 1'b1, load: 1'b0, bias_on: 1'b0, bias_bit: 7'd0, sh: SH_32};
			end
			S_T3: begin
				mac_a   = {17'd0, m_q[47:32]};
				mac_b   = {22'd0, RAD_US_TO_TURN[41:32]};
				mac_ctl = '{en: 1'b1, load: 1'b0, bias_on: 1'b0, bias_bit: 7'd0, sh: SH_64};
			end
			S_DXM: begin
				mac_a   = {3'd0, quo};
				mac_b   = cos_mag;
				mac_ctl = '{en: 1'b1, load: 1'b1, bias_on: 1'b1, bias_bit: 7'd29, sh: SH_0};
			end
			S_DYM: begin
				mac_a   = {3'd0, quo};
				mac_b   = sin_mag;
				mac_ctl = '{en: 1'b1, load: 1'b1, bias_on: 1'b1, bias_bit: 7'd29, sh: SH_0};
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			gain_q   <= GAIN_RESET;
			iht_q    <= INV_TRACK_RESET;
			x_q      <= '0;
			y_q      <= '0;
			hd_q     <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_SPEED_GAIN:     gain_q <= cfg.wdata;
					REG_INV_HALF_TRACK: iht_q  <= cfg.wdata;
					default:            ;
				endcase
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (pose.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (take_in) state_q <= S_SLM;
				S_SLM:  state_q <= S_SLF;
				S_SLF:  state_q <= S_SRM;
				S_SRM:  state_q <= S_SRF;
				S_SRF:  state_q <= S_RTM;
				S_RTM:  state_q <= S_RTF;
				S_RTF:  state_q <= S_DSM;
				S_DSM:  state_q <= S_DSF;
				S_DSF:  state_q <= S_D0;
				S_D0:   state_q <= S_D1;
				S_D1:   state_q <= S_D2;
				S_D2:   state_q <= S_D3;
				S_D3:   state_q <= S_RSM;
				S_RSM:  state_q <= S_T0;
				S_T0:   state_q <= S_T1;
				S_T1:   state_q <= S_T2;
				S_T2:   state_q <= S_T3;
				S_T3:   state_q <= S_TF;
				S_TF:   state_q <= S_WAIT;
				S_WAIT: if (cor_done) state_q <= S_DXM;
				S_DXM:  state_q <= S_DXF;
				S_DXF:  state_q <= S_DYM;
				S_DYM:  state_q <= S_DYF;
				S_DYF:  state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						x_q     <= x_q + dx_q;
						y_q     <= y_q + dy_q;
						hd_q    <= hd_q + turn_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			in_q <= meas.data;
		end
		case (state_q)
			S_SLM: neg_q <= in_q.left_count[15];
			S_SLF: sl_q <= sat_s32(acc[71:8], neg_q);
			S_SRM: neg_q <= in_q.right_count[15];
			S_SRF: sr_q <= sat_s32(acc[71:8], neg_q);
			S_RTM: neg_q <= diff[32];
			S_RTF: rate_q <= sat_s32(acc[87:24], neg_q);
			S_DSM: dneg_q <= sum[32];
			S_RSM: neg_q <= rate_q[31];
			S_T0:  m_q <= acc[47:0];
			S_TF:  turn_q <= q_turn;
			S_DXM: neg_q <= dneg_q ^ cor_cos[33];
			S_DXF: dx_q <= q_dxy;
			S_DYM: neg_q <= dneg_q ^ cor_sin[33];
			S_DYF: dy_q <= q_dxy;
			default: ;
		endcase
		if (out_load) begin
			out_q.left_speed  <= sl_q;
			out_q.right_speed <= sr_q;
			out_q.pos_x       <= x_q + dx_q;
			out_q.pos_y       <= y_q + dy_q;
			out_q.heading     <= hd_q + turn_q;
		end
	end

	assign pose.valid = ovalid_q;
	assign pose.data  = out_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid && !pose.ready |=> pose.valid && $stable(pose.data))
		else $error("waiting pose transaction changed");

	a_cordic_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DXM |-> cor_done)
		else $error("position update before cordic finished");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> state_q == S_SLM)
		else $error("accepted transaction did not start the sequence");

	a_heading_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!out_load |=> $stable(hd_q))
		else $error("heading changed outside result load");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> pose.valid)
		else $error("result load did not raise pose valid");

endmodule
